// File: rtl/tcst_pkg.sv
// ----------------------------------------------------------------------------
// tcst_pkg
// Shared widths, codes and controller/datapath handshake types for the
// touch contact slot tracker.
// ----------------------------------------------------------------------------
package tcst_pkg;

  localparam int NUM_SLOTS  = 4;
  localparam int SLOT_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  localparam int FID_W      = 32;
  localparam int RAW_X_W    = 11;
  localparam int RAW_Y_W    = 10;
  localparam int GAIN_W     = 17;
  localparam int POS_W      = 19;
  localparam int KIND_W     = 2;
  localparam int SIDX_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = GAIN_W;
  localparam int FRAC_SHIFT = 8;

  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  localparam logic FUNC_REPORT = 1'b0;
  localparam logic FUNC_FRAME  = 1'b1;

  localparam logic [KIND_W-1:0] EV_START = 2'd0;
  localparam logic [KIND_W-1:0] EV_MOVE  = 2'd1;
  localparam logic [KIND_W-1:0] EV_END   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_X = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Y = 2'd2;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 17'd65536;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [POS_W-1:0]  pos_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;     // latch a touch report
    logic frame;       // start a frame-end sweep
    logic scale;       // register the scaled coordinates
    logic update;      // commit the slot lookup
    logic sweep_emit;  // emit one end event
  } tcst_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic enable;
    logic func;
    logic upd_emit;
    logic out_free;
    logic mask_empty;
    logic sweep_last;
  } tcst_status_t;

  // Low bits of a slot number as carried on the result channel.
  function automatic logic [SIDX_W-1:0] slot_to_idx(slot_t s);
    logic [SLOT_W+SIDX_W-1:0] t;
    t = {{SIDX_W{1'b0}}, s};
    return t[SIDX_W-1:0];
  endfunction

endpackage

// File: rtl/tcst_if.sv
// ----------------------------------------------------------------------------
// tcst_if
// Valid/ready channels for touch input items and tracker events.
// ----------------------------------------------------------------------------
interface tcst_in_if;
  import tcst_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 func;
  logic [FID_W-1:0]     contact_id;
  logic [RAW_X_W-1:0]   panel_x;
  logic [RAW_Y_W-1:0]   panel_y;

  modport source (output valid, func, contact_id, panel_x, panel_y, input ready);
  modport sink   (input valid, func, contact_id, panel_x, panel_y, output ready);
endinterface

interface tcst_out_if;
  import tcst_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [KIND_W-1:0]    event_kind;
  logic [SIDX_W-1:0]    slot_index;
  logic [POS_W-1:0]     pos_x;
  logic [POS_W-1:0]     pos_y;
  logic                 last;

  modport source (output valid, event_kind, slot_index, pos_x, pos_y, last, input ready);
  modport sink   (input valid, event_kind, slot_index, pos_x, pos_y, last, output ready);
endinterface

// File: rtl/tcst_ctrl.sv
// ----------------------------------------------------------------------------
// tcst_ctrl
// Sequencer: accept, scale, commit a report, or sweep end events.
// ----------------------------------------------------------------------------
module tcst_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  tcst_pkg::tcst_status_t status,
  output tcst_pkg::tcst_cmd_t    cmd
);
  import tcst_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCALE  = 2'd1;
  localparam logic [1:0] S_UPDATE = 2'd2;
  localparam logic [1:0] S_SWEEP  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_ready && in_valid;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        // disabled items are taken and dropped
        if (accept && status.enable) begin
          if (status.func == FUNC_REPORT) begin
            cmd.capture = 1'b1;
            state_nxt   = S_SCALE;
          end else begin
            cmd.frame = 1'b1;
            state_nxt = S_SWEEP;
          end
        end
      end
      S_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = S_UPDATE;
      end
      S_UPDATE: begin
        // hold while an event is due and the output register is full
        if (!status.upd_emit || status.out_free) begin
          cmd.update = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_SWEEP: begin
        if (status.mask_empty) begin
          state_nxt = S_IDLE;
        end else if (status.out_free) begin
          cmd.sweep_emit = 1'b1;
          if (status.sweep_last) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_update_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update |-> (!status.upd_emit || status.out_free))
    else $error("report committed into a full output register");

  a_capture_then_scale: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> cmd.scale)
    else $error("captured report not scaled next cycle");

  a_sweep_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sweep_emit |-> (status.out_free && !status.mask_empty))
    else $error("end event emitted without room or pending slot");
endmodule

// File: rtl/tcst_dp.sv
// ----------------------------------------------------------------------------
// tcst_dp
// Datapath: gain registers, coordinate scaling, slot table and event register.
// ----------------------------------------------------------------------------
module tcst_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [tcst_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tcst_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_func,
  input  logic [tcst_pkg::FID_W-1:0]      in_contact_id,
  input  logic [tcst_pkg::RAW_X_W-1:0]    in_panel_x,
  input  logic [tcst_pkg::RAW_Y_W-1:0]    in_panel_y,
  input  tcst_pkg::tcst_cmd_t             cmd,
  output tcst_pkg::tcst_status_t          status,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [tcst_pkg::KIND_W-1:0]     out_event_kind,
  output logic [tcst_pkg::SIDX_W-1:0]     out_slot_index,
  output logic [tcst_pkg::POS_W-1:0]      out_pos_x,
  output logic [tcst_pkg::POS_W-1:0]      out_pos_y,
  output logic                            out_last
);
  import tcst_pkg::*;

  localparam int PX_W = RAW_X_W + GAIN_W;
  localparam int PY_W = RAW_Y_W + GAIN_W;

  // configuration
  logic              enable_r;
  logic [GAIN_W-1:0] scale_x_r, scale_y_r;

  // captured report
  logic [FID_W-1:0]   fid_r;
  logic [RAW_X_W-1:0] raw_x_r;
  logic [RAW_Y_W-1:0] raw_y_r;
  pos_t               px_r, py_r;

  // slot table
  logic [NUM_SLOTS-1:0] active_r, seen_r, mask_r;
  logic [FID_W-1:0]     finger_r [NUM_SLOTS];
  pos_t                 spos_x_r [NUM_SLOTS];
  pos_t                 spos_y_r [NUM_SLOTS];

  // event register
  logic              ovalid_r;
  logic [KIND_W-1:0] okind_r;
  logic [SIDX_W-1:0] oslot_r;
  pos_t              opx_r, opy_r;
  logic              olast_r;

  logic [PX_W-1:0] prod_x;
  logic [PY_W-1:0] prod_y;
  pos_t            px_nxt, py_nxt;

  logic  hit_any, free_any, changed, upd_emit;
  slot_t hit_idx, free_idx, tgt_idx, end_idx;
  logic [NUM_SLOTS-1:0] mask_nxt;
  logic  out_free, load_upd, load_end;

  // Q16 gain, keep 8 fractional bits, saturate past 19 bits
  assign prod_x = PX_W'(raw_x_r) * PX_W'(scale_x_r);
  assign prod_y = PY_W'(raw_y_r) * PY_W'(scale_y_r);

  always_comb begin
    if (|prod_x[PX_W-1:POS_W+FRAC_SHIFT]) px_nxt = POS_MAX;
    else                                  px_nxt = prod_x[POS_W+FRAC_SHIFT-1:FRAC_SHIFT];
    // a 10-bit coordinate times a 17-bit gain always fits 19 bits after the shift
    py_nxt = prod_y[PY_W-1:FRAC_SHIFT];
  end

  // lookup: matching active slot first, else lowest free one
  always_comb begin
    hit_any  = 1'b0;
    free_any = 1'b0;
    hit_idx  = '0;
    free_idx = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (!hit_any && active_r[i] && (finger_r[i] == fid_r)) begin
        hit_any = 1'b1;
        hit_idx = SLOT_W'(i);
      end
      if (!free_any && !active_r[i]) begin
        free_any = 1'b1;
        free_idx = SLOT_W'(i);
      end
    end
  end

  assign changed  = (px_r != spos_x_r[hit_idx]) || (py_r != spos_y_r[hit_idx]);
  assign upd_emit = hit_any ? changed : free_any;
  assign tgt_idx  = hit_any ? hit_idx : free_idx;

  // sweep: lowest pending slot
  always_comb begin
    end_idx  = '0;
    mask_nxt = mask_r;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (mask_r[i]) end_idx = SLOT_W'(i);
    end
    mask_nxt[end_idx] = 1'b0;
  end

  assign out_free = !ovalid_r || out_ready;
  assign load_upd = cmd.update && upd_emit;
  assign load_end = cmd.sweep_emit;

  assign status.enable     = enable_r;
  assign status.func       = in_func;
  assign status.upd_emit   = upd_emit;
  assign status.out_free   = out_free;
  assign status.mask_empty = (mask_r == '0);
  assign status.sweep_last = (mask_nxt == '0);

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r  <= 1'b1;
      scale_x_r <= GAIN_RESET;
      scale_y_r <= GAIN_RESET;
      active_r  <= '0;
      seen_r    <= '0;
      mask_r    <= '0;
      ovalid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ENABLE:  enable_r  <= cfg_data[0];
          CFG_SCALE_X: scale_x_r <= cfg_data;
          CFG_SCALE_Y: scale_y_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.frame) begin
        // free unseen slots now; their positions stay for the end events
        mask_r   <= active_r & ~seen_r;
        active_r <= active_r & seen_r;
        seen_r   <= '0;
      end else if (cmd.update && (hit_any || free_any)) begin
        active_r[tgt_idx] <= 1'b1;
        seen_r[tgt_idx]   <= 1'b1;
      end
      if (load_end) mask_r <= mask_nxt;
      if (load_upd || load_end) ovalid_r <= 1'b1;
      else if (out_ready)       ovalid_r <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      fid_r   <= in_contact_id;
      raw_x_r <= in_panel_x;
      raw_y_r <= in_panel_y;
    end
    if (cmd.scale) begin
      px_r <= px_nxt;
      py_r <= py_nxt;
    end
    if (cmd.update && (hit_any || free_any)) begin
      finger_r[tgt_idx] <= fid_r;
      spos_x_r[tgt_idx] <= px_r;
      spos_y_r[tgt_idx] <= py_r;
    end
    if (load_upd) begin
      okind_r <= hit_any ? EV_MOVE : EV_START;
      oslot_r <= slot_to_idx(tgt_idx);
      opx_r   <= px_r;
      opy_r   <= py_r;
      olast_r <= 1'b1;
    end else if (load_end) begin
      okind_r <= EV_END;
      oslot_r <= slot_to_idx(end_idx);
      opx_r   <= spos_x_r[end_idx];
      opy_r   <= spos_y_r[end_idx];
      olast_r <= (mask_nxt == '0);
    end
  end

  assign out_valid      = ovalid_r;
  assign out_event_kind = okind_r;
  assign out_slot_index = oslot_r;
  assign out_pos_x      = opx_r;
  assign out_pos_y      = opy_r;
  assign out_last       = olast_r;

  a_pending_not_active: assert property (@(posedge clk) disable iff (!rst_n)
    (mask_r & active_r) == '0)
    else $error("slot pending an end event is still active");

  a_frame_clears_seen: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.frame |=> (seen_r == '0))
    else $error("seen marks survive a frame end");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r |-> (okind_r == EV_START || okind_r == EV_MOVE || okind_r == EV_END))
    else $error("illegal event kind in output register");
endmodule

// File: rtl/touch_contact_slot_tracker.sv
// Touch report: accepted, scaled, then committed once the event register has
//   room for a due event; its start/move event is visible the cycle after the
//   commit. Frame end: accepted, then one end event per ended slot, each as the
//   event register has room. A new item is taken only when the last is done.
// Reset (synchronous, rst_n low): slot table empty, enable 1, gains 1.0.
// ----------------------------------------------------------------------------
// touch_contact_slot_tracker
// Tracks touch contacts across frames on a small slot table and emits
// start, move and end events with coordinates scaled by a Q16 gain (8 fraction bits).
// ----------------------------------------------------------------------------
module touch_contact_slot_tracker (
  input  logic                            clk,
  input  logic                            rst_n,
  tcst_in_if.sink                         in_ch,
  tcst_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [tcst_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tcst_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tcst_pkg::*;

  // Command and status bundles between the sequencer and the datapath.
  tcst_cmd_t    cmd;
  tcst_status_t status;

  // Sequencer: owns the input handshake. A new transaction is taken only when
  // the previous item has been fully processed; a pending event in the output
  // register does not block accepting the next transaction.
  tcst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath: configuration registers, scaling, slot table, and the event
  // register that drives the result channel.
  tcst_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_func        (in_ch.func),
    .in_contact_id  (in_ch.contact_id),
    .in_panel_x     (in_ch.panel_x),
    .in_panel_y     (in_ch.panel_y),
    .cmd            (cmd),
    .status         (status),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .out_event_kind (out_ch.event_kind),
    .out_slot_index (out_ch.slot_index),
    .out_pos_x      (out_ch.pos_x),
    .out_pos_y      (out_ch.pos_y),
    .out_last       (out_ch.last)
  );
endmodule
